// ===== rtl/dbrc_pkg.sv =====
// ---------------------------------------------------------------------------
// dbrc_pkg
// Shared constants, codes and types of the DHCP boot request classifier.
// ---------------------------------------------------------------------------
package dbrc_pkg;

	// Fixed layout of a BOOTP/DHCP datagram.
	localparam logic [9:0]  COOKIE_OFFSET  = 10'd236;
	localparam logic [9:0]  OPTIONS_OFFSET = 10'd240;
	// A datagram whose last byte sits at this offset or below is too short.
	localparam logic [9:0]  MIN_LAST_POS   = 10'd243;
	localparam logic [9:0]  POS_MAX        = 10'd1023;
	localparam logic [31:0] COOKIE_VALUE   = 32'h63825363;

	// Option walk settings.
	localparam logic [7:0]  OPTION_TAG     = 8'd53;
	localparam logic [7:0]  END_TAG        = 8'd255;
	localparam logic [9:0]  SEARCH_LIMIT   = 10'd312;
	localparam logic [9:0]  MAX_PACKET     = 10'd600;

	// Op code of a boot request and the message types that get an answer.
	localparam logic [7:0]  OP_BOOTREQUEST = 8'd1;
	localparam logic [7:0]  MSG_DISCOVER   = 8'd1;
	localparam logic [7:0]  MSG_REQUEST    = 8'd3;

	typedef enum logic [1:0] {
		REPLY_NONE  = 2'd0,
		REPLY_OFFER = 2'd1,
		REPLY_ACK   = 2'd2,
		REPLY_BOOTP = 2'd3
	} reply_kind_t;

	typedef enum logic [2:0] {
		PH_TAG      = 3'd0,
		PH_SKIP_LEN = 3'd1,
		PH_SKIPPING = 3'd2,
		PH_HIT_LEN  = 3'd3,
		PH_HIT_VAL  = 3'd4,
		PH_FOUND    = 3'd5,
		PH_MISS     = 3'd6
	} walk_phase_t;

	// Control from the top level to the option walker.
	typedef struct packed {
		logic step;   // consume this byte as an option byte
		logic clear;  // datagram ends with this byte: return to reset state
	} walk_ctrl_t;

	// Walk result including the byte that is being consumed now.
	typedef struct packed {
		logic       found;
		logic [7:0] type_value;
	} walk_status_t;

endpackage

// ===== rtl/dhcp_boot_request_classifier.sv =====
// ---------------------------------------------------------------------------
// dhcp_boot_request_classifier
// Classifies a received DHCP/BOOTP boot request streamed one byte per item.
// ---------------------------------------------------------------------------
// Throughput: one byte item per clock cycle, sustained, while the result side
//   takes results; only a last byte waits when an earlier result is unread.
// Result: reply_valid is registered and rises as a last byte leaves the input
//   register; the result is held until it is taken.
// Reset: arst_n clears the input and result valid flags and all datagram
//   state; the block is ready for the first byte of a datagram right away.
module dhcp_boot_request_classifier import dbrc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       data_valid,
	output logic       data_stall,
	input  logic [7:0] data_byte,
	input  logic       last_byte,
	output logic       reply_valid,
	input  logic       reply_stall,
	output logic [1:0] reply_kind,
	output logic [7:0] message_type,
	output logic       type_found
);

	// Input register. Each accepted byte is held here while the running
	// datagram state is updated from it.
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;

	// Running datagram state.
	logic [9:0]  pos_q;
	logic [7:0]  op_q, op_nx;
	logic [31:0] cookie_q, cookie_nx;

	// Result register.
	logic [1:0] kind_q;
	logic [7:0] mtype_q;
	logic       found_q;

	logic         adv;
	logic         load;
	logic         in_range;
	logic         end_pkt;
	walk_ctrl_t   wctrl;
	walk_status_t wstat;
	logic         good_cookie;
	logic         found_c;
	logic [7:0]   tv_c;
	reply_kind_t  kind_c;

	// A byte that is not the last one produces nothing and always moves on.
	// A last byte needs the result register to be free or being read.
	assign adv        = valid_s1 && (!last_s1 || !reply_valid || !reply_stall);
	assign data_stall = valid_s1 && !adv;
	assign load       = data_valid && !data_stall;
	assign end_pkt    = adv && last_s1;

	// Bytes past the receive buffer size are dropped from parsing, but the
	// datagram still ends at its marked last byte.
	assign in_range = pos_q < MAX_PACKET;

	always_comb begin
		op_nx     = op_q;
		cookie_nx = cookie_q;
		if (in_range && pos_q == 10'd0) begin
			op_nx = byte_s1;
		end
		if (in_range && pos_q >= COOKIE_OFFSET && pos_q < OPTIONS_OFFSET) begin
			cookie_nx = {cookie_q[23:0], byte_s1};
		end
	end

	assign wctrl.step  = adv && in_range && (pos_q >= OPTIONS_OFFSET);
	assign wctrl.clear = end_pkt;

	dbrc_opt_walker u_walker (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (wctrl),
		.data_byte (byte_s1),
		.status    (wstat)
	);

	// Classification, using the state as it stands after the last byte.
	// A datagram that ends before the option's value byte leaves the found
	// flag clear, so it counts as not found.
	always_comb begin
		good_cookie = cookie_nx == COOKIE_VALUE;
		found_c     = good_cookie && wstat.found;
		tv_c        = found_c ? wstat.type_value : 8'd0;
		if (pos_q <= MIN_LAST_POS) begin
			kind_c  = REPLY_NONE;
			found_c = 1'b0;
			tv_c    = 8'd0;
		end else if (op_nx != OP_BOOTREQUEST) begin
			kind_c = REPLY_NONE;
		end else if (!found_c) begin
			kind_c = REPLY_BOOTP;
		end else if (tv_c == MSG_DISCOVER) begin
			kind_c = REPLY_OFFER;
		end else if (tv_c == MSG_REQUEST) begin
			kind_c = REPLY_ACK;
		end else begin
			kind_c = REPLY_NONE;
		end
	end

	// Input register control and payload.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			byte_s1 <= data_byte;
			last_s1 <= last_byte;
		end
	end

	// Datagram state: updated per byte, back to reset after the last byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= 10'd0;
			op_q     <= 8'd0;
			cookie_q <= 32'd0;
		end else if (end_pkt) begin
			pos_q    <= 10'd0;
			op_q     <= 8'd0;
			cookie_q <= 32'd0;
		end else if (adv) begin
			if (pos_q != POS_MAX) begin
				pos_q <= pos_q + 10'd1;
			end
			op_q     <= op_nx;
			cookie_q <= cookie_nx;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reply_valid <= 1'b0;
		end else if (end_pkt) begin
			reply_valid <= 1'b1;
		end else if (!reply_stall) begin
			reply_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (end_pkt) begin
			kind_q  <= kind_c;
			mtype_q <= tv_c;
			found_q <= found_c;
		end
	end

	assign reply_kind   = kind_q;
	assign message_type = mtype_q;
	assign type_found   = found_q;

	// An offer or an ack is only given for a located message type.
	a_answer_needs_type: assert property (@(posedge clk) disable iff (!arst_n)
		reply_valid && (reply_kind == REPLY_OFFER || reply_kind == REPLY_ACK)
		|-> type_found)
		else $error("offer or ack without a located message type");

	// A plain BOOTP reply means the message type was not located.
	a_bootp_no_type: assert property (@(posedge clk) disable iff (!arst_n)
		reply_valid && reply_kind == REPLY_BOOTP |-> !type_found)
		else $error("BOOTP reply with a located message type");

	// The reported type is zero whenever no type was located.
	a_type_zero: assert property (@(posedge clk) disable iff (!arst_n)
		reply_valid && !type_found |-> message_type == 8'd0)
		else $error("message type reported without a located option");

	// The end of a datagram yields a result and restarts the byte count.
	a_end_result: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && last_s1 && adv |=> reply_valid && pos_q == 10'd0)
		else $error("last byte did not produce a result or restart");

endmodule

// ===== rtl/dbrc_opt_walker.sv =====
// ---------------------------------------------------------------------------
// dbrc_opt_walker
// Walks the option TLV list one byte per cycle while the classifier steps it, and locates the message type.
// ---------------------------------------------------------------------------
module dbrc_opt_walker import dbrc_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  walk_ctrl_t   ctrl,
	input  logic [7:0]   data_byte,
	output walk_status_t status
);

	walk_phase_t phase_q, phase_nx;
	logic [7:0]  skip_count_q, skip_count_nx;
	logic [9:0]  skip_budget_q, skip_budget_nx;
	logic        found_q, found_nx;
	logic [7:0]  type_value_q, type_value_nx;
	logic [10:0] budget_sum;
	logic [7:0]  skip_dec;
	logic        budget_left;

	assign budget_sum  = {1'b0, skip_budget_q} + {3'b000, data_byte} + 11'd1;
	assign skip_dec    = skip_count_q - 8'd1;
	assign budget_left = skip_budget_q < SEARCH_LIMIT;

	// Next state of the walk.
	always_comb begin
		phase_nx       = phase_q;
		skip_count_nx  = skip_count_q;
		skip_budget_nx = skip_budget_q;
		found_nx       = found_q;
		type_value_nx  = type_value_q;
		if (ctrl.step) begin
			case (phase_q)
				PH_TAG: begin
					if (data_byte == OPTION_TAG && budget_left) begin
						phase_nx = PH_HIT_LEN;
					end else if (data_byte == END_TAG || !budget_left) begin
						phase_nx = PH_MISS;
					end else begin
						phase_nx = PH_SKIP_LEN;
					end
				end
				PH_SKIP_LEN: begin
					skip_budget_nx = budget_sum[10] ? POS_MAX : budget_sum[9:0];
					skip_count_nx  = data_byte;
					phase_nx       = (data_byte == 8'd0) ? PH_TAG : PH_SKIPPING;
				end
				PH_SKIPPING: begin
					skip_count_nx = skip_dec;
					if (skip_dec == 8'd0) begin
						phase_nx = PH_TAG;
					end
				end
				PH_HIT_LEN: begin
					phase_nx = PH_HIT_VAL;
				end
				PH_HIT_VAL: begin
					type_value_nx = data_byte;
					found_nx      = 1'b1;
					phase_nx      = PH_FOUND;
				end
				default: begin
					phase_nx = phase_q;
				end
			endcase
		end
	end

	// Status seen by the classifier, including the current byte.
	always_comb begin
		status.found      = found_nx;
		status.type_value = type_value_nx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_TAG;
			skip_count_q  <= 8'd0;
			skip_budget_q <= 10'd0;
			found_q       <= 1'b0;
			type_value_q  <= 8'd0;
		end else if (ctrl.clear) begin
			phase_q       <= PH_TAG;
			skip_count_q  <= 8'd0;
			skip_budget_q <= 10'd0;
			found_q       <= 1'b0;
			type_value_q  <= 8'd0;
		end else begin
			phase_q       <= phase_nx;
			skip_count_q  <= skip_count_nx;
			skip_budget_q <= skip_budget_nx;
			found_q       <= found_nx;
			type_value_q  <= type_value_nx;
		end
	end

endmodule

// ===== verif/tb_dhcp_boot_request_classifier.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_dhcp_boot_request_classifier
// Streams whole boot request datagrams into the classifier one byte per
// item and checks every reply against a hand-written one or a cycle-free model.
// A table of hand-built datagrams comes first, then random datagrams that
// are mostly well formed, with short and junk datagrams mixed in.
// ---------------------------------------------------------------------------
module tb_dhcp_boot_request_classifier;
	import dbrc_pkg::*;

	// Random datagrams after the table. Each one gives exactly one reply.
	localparam int unsigned RANDOM_DGRAMS = 70;
	// The last datagrams run without any idling on either side.
	localparam int unsigned QUIET_TAIL    = 10;
	// Cycles without any handshake before the run is declared hung.
	localparam int unsigned STUCK_LIMIT   = 2000;

	// One reply as the result side presents it.
	typedef struct packed {
		reply_kind_t kind;
		logic [7:0]  mtype;
		logic        found;
	} reply_t;

	// Recipe for one datagram: a fixed header and cookie, some options to be
	// skipped, then a target option, padded or cut to the requested length.
	// Rows marked typed carry a reply written by hand.
	typedef struct {
		int unsigned len;
		logic [7:0]  op;
		logic [31:0] cookie;
		int unsigned nskip;
		int unsigned skiplen;
		logic [7:0]  tag;
		logic [7:0]  tlen;
		logic [7:0]  tval;
		bit          typed;
		reply_kind_t kind;
		logic [7:0]  mtype;
		logic        found;
	} dgram_row_t;

	logic       clk;
	logic       arst_n;
	logic       data_valid;
	logic       data_stall;
	logic [7:0] data_byte;
	logic       last_byte;
	logic       reply_valid;
	logic       reply_stall;
	logic [1:0] reply_kind;
	logic [7:0] message_type;
	logic       type_found;

	// Replies still owed by the block, oldest first.
	reply_t      pending_replies[$];
	// Bytes of the datagram being sent.
	logic [7:0]  dgram_bytes[$];
	dgram_row_t  directed_rows[$];
	int unsigned errors;
	// Cleared to give stretches of full-rate traffic on both sides.
	bit          idling_on;

	// Model state of the classifier, updated on each accepted byte.
	logic [9:0]  rx_pos;
	logic [7:0]  rx_op;
	logic [31:0] rx_cookie;
	walk_phase_t rx_phase;
	logic [7:0]  rx_skip_left;
	logic [9:0]  rx_budget;
	logic        rx_found;
	logic [7:0]  rx_type;

	dhcp_boot_request_classifier u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.data_valid   (data_valid),
		.data_stall   (data_stall),
		.data_byte    (data_byte),
		.last_byte    (last_byte),
		.reply_valid  (reply_valid),
		.reply_stall  (reply_stall),
		.reply_kind   (reply_kind),
		.message_type (message_type),
		.type_found   (type_found)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Back to the state of an idle block waiting for offset zero.
	task automatic clear_classifier();
		rx_pos       = '0;
		rx_op        = '0;
		rx_cookie    = '0;
		rx_phase     = PH_TAG;
		rx_skip_left = '0;
		rx_budget    = '0;
		rx_found     = 1'b0;
		rx_type      = '0;
	endtask

	// Advances the model by one accepted byte. On the last byte of a
	// datagram it classifies the datagram, hands back the reply and clears.
	task automatic classify_byte(input logic [7:0] b, input logic lst,
			output logic produced, output reply_t r);
		logic [9:0]  pos;
		logic [10:0] budget_sum;
		logic        good_cookie;
		logic        fnd;
		logic [7:0]  tv;
		pos = rx_pos;
		// Bytes past the receive buffer size are dropped, only counted.
		if (pos < MAX_PACKET) begin
			if (pos == 10'd0)
				rx_op = b;
			if (pos >= COOKIE_OFFSET && pos < OPTIONS_OFFSET)
				rx_cookie = {rx_cookie[23:0], b};
			// Option walk: every tag, pad included, has a length byte. The
			// budget counts skipped bytes and ends the search once spent.
			if (pos >= OPTIONS_OFFSET) begin
				case (rx_phase)
					PH_TAG: begin
						if (b == OPTION_TAG && rx_budget < SEARCH_LIMIT)
							rx_phase = PH_HIT_LEN;
						else if (b == END_TAG || rx_budget >= SEARCH_LIMIT)
							rx_phase = PH_MISS;
						else
							rx_phase = PH_SKIP_LEN;
					end
					PH_SKIP_LEN: begin
						budget_sum   = {1'b0, rx_budget} + b + 11'd1;
						rx_budget    = (budget_sum > POS_MAX) ? POS_MAX : budget_sum[9:0];
						rx_skip_left = b;
						rx_phase     = (b == 8'd0) ? PH_TAG : PH_SKIPPING;
					end
					PH_SKIPPING: begin
						rx_skip_left = rx_skip_left - 8'd1;
						if (rx_skip_left == 8'd0)
							rx_phase = PH_TAG;
					end
					// The length of the located option does not matter.
					PH_HIT_LEN: rx_phase = PH_HIT_VAL;
					PH_HIT_VAL: begin
						rx_type  = b;
						rx_found = 1'b1;
						rx_phase = PH_FOUND;
					end
					default: ;
				endcase
			end
		end
		if (rx_pos != POS_MAX)
			rx_pos = rx_pos + 10'd1;

		produced = lst;
		r        = '0;
		if (lst) begin
			good_cookie = (rx_cookie == COOKIE_VALUE);
			fnd         = good_cookie && rx_found;
			tv          = fnd ? rx_type : 8'd0;
			// A short datagram reports nothing at all; other no-reply cases
			// still report what the walk found.
			if (pos <= MIN_LAST_POS) begin
				r.kind = REPLY_NONE;
				fnd    = 1'b0;
				tv     = 8'd0;
			end else if (rx_op != OP_BOOTREQUEST)
				r.kind = REPLY_NONE;
			else if (!fnd)
				r.kind = REPLY_BOOTP;
			else if (tv == MSG_DISCOVER)
				r.kind = REPLY_OFFER;
			else if (tv == MSG_REQUEST)
				r.kind = REPLY_ACK;
			else
				r.kind = REPLY_NONE;
			r.mtype = tv;
			r.found = fnd;
			clear_classifier();
		end
	endtask

	task automatic add_row(input int unsigned len, input logic [7:0] op,
			input logic [31:0] cookie, input int unsigned nskip,
			input int unsigned skiplen, input logic [7:0] tag, input logic [7:0] tlen,
			input logic [7:0] tval, input bit typed, input reply_kind_t kind,
			input logic [7:0] mtype, input logic found);
		dgram_row_t r;
		r = '{len, op, cookie, nskip, skiplen, tag, tlen, tval, typed, kind, mtype, found};
		directed_rows.push_back(r);
	endtask

	// Lays out a datagram from its recipe. Header bytes, skipped tags and
	// their data and the tail are random.
	task automatic build_dgram(input dgram_row_t row);
		logic [7:0]  t;
		int unsigned n;
		dgram_bytes.delete();
		dgram_bytes.push_back(row.op);
		while (dgram_bytes.size() < COOKIE_OFFSET)
			dgram_bytes.push_back(8'($urandom));
		for (n = 0; n < 4; n++)
			dgram_bytes.push_back(row.cookie[31 - 8 * n -: 8]);
		for (n = 0; n < row.nskip; n++) begin
			// Skipped tags are never the target or the end tag; pads are
			// frequent because they get no special treatment.
			if ($urandom_range(0, 3) == 0) begin
				t = 8'd0;
			end else begin
				do t = 8'($urandom_range(0, 254)); while (t == OPTION_TAG);
			end
			dgram_bytes.push_back(t);
			dgram_bytes.push_back(8'(row.skiplen));
			repeat (row.skiplen) dgram_bytes.push_back(8'($urandom));
		end
		dgram_bytes.push_back(row.tag);
		dgram_bytes.push_back(row.tlen);
		dgram_bytes.push_back(row.tval);
		while (dgram_bytes.size() < row.len)
			dgram_bytes.push_back(8'($urandom));
		while (dgram_bytes.size() > row.len)
			void'(dgram_bytes.pop_back());
	endtask

	function automatic dgram_row_t random_row();
		dgram_row_t  r;
		int unsigned pick;
		int unsigned natural_len;
		r.typed   = 1'b0;
		r.kind    = REPLY_NONE;
		r.mtype   = '0;
		r.found   = 1'b0;
		pick      = $urandom_range(0, 99);
		r.op      = ($urandom_range(0, 9) == 0) ? 8'($urandom) : OP_BOOTREQUEST;
		r.cookie  = ($urandom_range(0, 9) == 0) ?
			COOKIE_VALUE ^ (32'd1 << $urandom_range(0, 31)) : COOKIE_VALUE;
		r.nskip   = $urandom_range(0, 4);
		r.skiplen = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) :
			$urandom_range(0, 40);
		case ($urandom_range(0, 15))
			0, 1: r.tag = END_TAG;
			2: r.tag = 8'($urandom);
			default: r.tag = OPTION_TAG;
		endcase
		r.tlen = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'd1;
		case ($urandom_range(0, 3))
			0: r.tval = MSG_DISCOVER;
			1: r.tval = MSG_REQUEST;
			2: r.tval = 8'($urandom);
			default: r.tval = 8'($urandom_range(0, 8));
		endcase
		// Length at which the target option's value byte is the last one.
		natural_len = OPTIONS_OFFSET + r.nskip * (r.skiplen + 2) + 3;
		if (pick < 70) begin
			case ($urandom_range(0, 19))
				// Ends on the length or tag byte of the target, or on the byte before it.
				0, 1: r.len = natural_len - $urandom_range(1, 3);
				// Runs past the receive buffer, sometimes past the counter.
				2: r.len = $urandom_range(600, 1100);
				default: r.len = natural_len + $urandom_range(0, 30);
			endcase
		end else if (pick < 85) begin
			r.len = $urandom_range(1, 244);
		end else begin
			// Junk: any op, bad cookies half the time, any target tag.
			r.op     = $urandom_range(0, 1) ? OP_BOOTREQUEST : 8'($urandom);
			r.cookie = $urandom_range(0, 1) ? COOKIE_VALUE : $urandom;
			r.nskip  = $urandom_range(0, 6);
			r.tag    = 8'($urandom);
			r.len    = $urandom_range(245, 500);
		end
		return r;
	endfunction

	// Offers one byte item at the falling edge, after an occasional idle
	// burst, and returns at the rising edge where it is taken.
	task automatic send_item(input logic [7:0] b, input logic lst);
		int unsigned gap;
		if (idling_on && $urandom_range(0, 63) == 0) begin
			gap = $urandom_range(1, 18);
			@(negedge clk);
			data_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		data_valid <= 1'b1;
		data_byte  <= b;
		last_byte  <= lst;
		@(posedge clk);
		while (data_stall) @(posedge clk);
	endtask

	task automatic send_dgram(input dgram_row_t row);
		int unsigned i;
		logic        produced;
		reply_t      predicted;
		reply_t      typed_reply;
		build_dgram(row);
		for (i = 0; i < dgram_bytes.size(); i++) begin
			send_item(dgram_bytes[i], i == dgram_bytes.size() - 1);
			classify_byte(dgram_bytes[i], i == dgram_bytes.size() - 1, produced, predicted);
			if (produced) begin
				typed_reply.kind  = row.kind;
				typed_reply.mtype = row.mtype;
				typed_reply.found = row.found;
				pending_replies.push_back(row.typed ? typed_reply : predicted);
			end
		end
	endtask

	// The sender stops until every owed reply has come out.
	task automatic hold_until_drained();
		@(negedge clk);
		data_valid <= 1'b0;
		while (pending_replies.size() != 0) @(posedge clk);
	endtask

	initial begin : stimulus
		int unsigned k;
		errors     = 0;
		idling_on  = 1'b1;
		data_valid = 1'b0;
		data_byte  = 8'd0;
		last_byte  = 1'b0;
		arst_n     = 1'b0;
		clear_classifier();

		// Directed datagrams. Columns: length, op, cookie, skipped options
		// and their data length, target tag, its length and value, then the
		// reply where it is obvious from the classification rules.
		add_row(1, OP_BOOTREQUEST, COOKIE_VALUE, 0, 0, OPTION_TAG, 1, MSG_DISCOVER,
			1, REPLY_NONE, 8'd0, 1'b0);
		// Too short by one byte even though the type option is complete.
		add_row(244, OP_BOOTREQUEST, COOKIE_VALUE, 0, 0, OPTION_TAG, 1, MSG_DISCOVER,
			1, REPLY_NONE, 8'd0, 1'b0);
		add_row(245, OP_BOOTREQUEST, COOKIE_VALUE, 0, 0, OPTION_TAG, 1, MSG_DISCOVER,
			1, REPLY_OFFER, MSG_DISCOVER, 1'b1);
		add_row(300, OP_BOOTREQUEST, COOKIE_VALUE, 0, 0, OPTION_TAG, 1, MSG_REQUEST,
			1, REPLY_ACK, MSG_REQUEST, 1'b1);
		// The value byte is taken even when the option claims no length.
		add_row(300, OP_BOOTREQUEST, COOKIE_VALUE, 0, 0, OPTION_TAG, 0, 8'd0,
			1, REPLY_NONE, 8'd0, 1'b1);
		add_row(300, OP_BOOTREQUEST, COOKIE_VALUE, 0, 0, OPTION_TAG, 255, 8'd255,
			1, REPLY_NONE, 8'd255, 1'b1);
		// Not a boot request: no reply, but the walk is still reported.
		add_row(300, 8'd2, COOKIE_VALUE, 0, 0, OPTION_TAG, 1, MSG_DISCOVER,
			1, REPLY_NONE, MSG_DISCOVER, 1'b1);
		add_row(300, 8'd255, COOKIE_VALUE, 0, 0, OPTION_TAG, 1, MSG_REQUEST,
			1, REPLY_NONE, MSG_REQUEST, 1'b1);
		add_row(300, 8'd0, COOKIE_VALUE, 0, 0, OPTION_TAG, 1, MSG_REQUEST,
			1, REPLY_NONE, MSG_REQUEST, 1'b1);
		// Bad cookies hide the option; a boot request falls back to a plain BOOTP reply.
		add_row(300, OP_BOOTREQUEST, COOKIE_VALUE ^ 32'd1, 0, 0, OPTION_TAG, 1,
			MSG_DISCOVER, 1, REPLY_BOOTP, 8'd0, 1'b0);
		add_row(300, OP_BOOTREQUEST, 32'hFFFF_FFFF, 0, 0, OPTION_TAG, 1, MSG_DISCOVER,
			1, REPLY_BOOTP, 8'd0, 1'b0);
		add_row(300, 8'd0, 32'h0, 0, 0, OPTION_TAG, 1, MSG_DISCOVER,
			1, REPLY_NONE, 8'd0, 1'b0);
		// End tag before the type option.
		add_row(300, OP_BOOTREQUEST, COOKIE_VALUE, 0, 0, END_TAG, 1, MSG_DISCOVER,
			1, REPLY_BOOTP, 8'd0, 1'b0);
		// Zero-length options and pads in front of the target.
		add_row(300, OP_BOOTREQUEST, COOKIE_VALUE, 3, 0, OPTION_TAG, 1, MSG_DISCOVER,
			0, REPLY_NONE, 8'd0, 1'b0);
		// Skip budget just under and exactly at the search limit.
		add_row(560, OP_BOOTREQUEST, COOKIE_VALUE, 2, 154, OPTION_TAG, 1, MSG_DISCOVER,
			0, REPLY_NONE, 8'd0, 1'b0);
		add_row(560, OP_BOOTREQUEST, COOKIE_VALUE, 2, 155, OPTION_TAG, 1, MSG_DISCOVER,
			0, REPLY_NONE, 8'd0, 1'b0);
		// Datagram ends on the target tag, on its length, then on its value.
		add_row(253, OP_BOOTREQUEST, COOKIE_VALUE, 1, 10, OPTION_TAG, 1, MSG_DISCOVER,
			1, REPLY_BOOTP, 8'd0, 1'b0);
		add_row(254, OP_BOOTREQUEST, COOKIE_VALUE, 1, 10, OPTION_TAG, 1, MSG_DISCOVER,
			1, REPLY_BOOTP, 8'd0, 1'b0);
		add_row(255, OP_BOOTREQUEST, COOKIE_VALUE, 1, 10, OPTION_TAG, 1, MSG_DISCOVER,
			1, REPLY_OFFER, MSG_DISCOVER, 1'b1);
		// Ends in the middle of a skipped option; then a skipped option of the greatest length.
		add_row(300, OP_BOOTREQUEST, COOKIE_VALUE, 1, 100, OPTION_TAG, 1, MSG_DISCOVER,
			1, REPLY_BOOTP, 8'd0, 1'b0);
		add_row(600, OP_BOOTREQUEST, COOKIE_VALUE, 1, 255, OPTION_TAG, 1, MSG_REQUEST,
			0, REPLY_NONE, 8'd0, 1'b0);
		// Longer than the receive buffer, and longer than the byte counter.
		add_row(700, OP_BOOTREQUEST, COOKIE_VALUE, 0, 0, OPTION_TAG, 1, MSG_REQUEST,
			1, REPLY_ACK, MSG_REQUEST, 1'b1);
		add_row(1100, OP_BOOTREQUEST, COOKIE_VALUE, 0, 0, OPTION_TAG, 1, MSG_DISCOVER,
			1, REPLY_OFFER, MSG_DISCOVER, 1'b1);

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (directed_rows[i])
			send_dgram(directed_rows[i]);
		hold_until_drained();

		// Random datagrams. Idling is switched off now and then for whole
		// datagrams, and for good over the tail of the run.
		for (k = 0; k < RANDOM_DGRAMS; k++) begin
			idling_on = (k < RANDOM_DGRAMS - QUIET_TAIL) && ($urandom_range(0, 3) != 0);
			if (k % 16 == 15)
				hold_until_drained();
			send_dgram(random_row());
		end
		@(negedge clk);
		data_valid <= 1'b0;

		// The watchdog covers a reply that never comes.
		while (pending_replies.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	// Result side: stall bursts of random length while idling is allowed.
	initial begin : reply_sink
		int unsigned hold;
		hold        = 0;
		reply_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold == 0 && idling_on && $urandom_range(0, 5) == 0)
				hold = $urandom_range(1, 18);
			if (hold != 0) begin
				reply_stall <= 1'b1;
				hold--;
			end else begin
				reply_stall <= 1'b0;
			end
		end
	end

	// Every reply taken is compared with the oldest one owed.
	always @(posedge clk) begin : reply_check
		reply_t want;
		if (arst_n && reply_valid && !reply_stall) begin
			if (pending_replies.size() == 0) begin
				$error("reply with none owed: reply_kind %0d message_type %0d type_found %0d",
					reply_kind, message_type, type_found);
				errors++;
			end else begin
				want = pending_replies.pop_front();
				if (reply_kind !== want.kind) begin
					$error("reply_kind: expected %0d, actual %0d", want.kind, reply_kind);
					errors++;
				end
				if (message_type !== want.mtype) begin
					$error("message_type: expected %0d, actual %0d", want.mtype, message_type);
					errors++;
				end
				if (type_found !== want.found) begin
					$error("type_found: expected %0d, actual %0d", want.found, type_found);
					errors++;
				end
			end
		end
	end

	// Ends a hung run: counts cycles in which neither side hands over an item.
	initial begin : watchdog
		int unsigned stuck_cycles;
		stuck_cycles = 0;
		while (stuck_cycles < STUCK_LIMIT) begin
			@(posedge clk);
			if ((data_valid && !data_stall) || (reply_valid && !reply_stall))
				stuck_cycles = 0;
			else
				stuck_cycles++;
		end
		$display("status: fail");
		$finish;
	end

endmodule
